// ===== design/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

    localparam int MAX_FRAMES    = 16;
    localparam int PAGE_BITS     = 16;
    localparam int CFG_W         = 5;
    localparam int FRAME_INDEX_W = 4;
    localparam int TOTAL_W       = 32;

    // frame number and recency rank widths
    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    // scan counter can hold the frame count itself
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(MAX_FRAMES);

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } lru_cmd_t;

    typedef struct packed {
        logic scan_last;
    } lru_status_t;

endpackage

`default_nettype wire

// ===== design/lru_page_replacement.sv =====
// LRU page replacement over a fully associative set of up to 16 frames.
//
// Input: drive page_number and pulse start; the beat is taken on a rising
// edge with start high and busy low. busy stays high while the reference
// is processed.
// Output: one result beat per reference, shown for exactly one cycle with
// result_valid high: hit, frame_index, evicted_valid, evicted_page and the
// saturating hit_total / fault_total. The receiver cannot stall; the beat
// is simply gone after that cycle, and the next reference may be started
// in that same cycle.
// Sequence: the scan state walks the frame table one entry per cycle over
// N frames, where N is the active frame count (frames_in_use clamped to
// 1..16), then the update state writes the table and the result beat is
// registered from it. A new reference is taken only once busy is low again.
// The scan tracks first match, first empty frame and the oldest frame.
// Config: cfg_valid/cfg_ready write frames_in_use; ready while idle.
// Reset (rst_n, async low): all frames empty, ranks and totals zero,
// frames_in_use = 16.
`default_nettype none

module lru_page_replacement
    import lru_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [PAGE_BITS-1:0]     page_number,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_W-1:0]         cfg_data,
    output logic                          result_valid,
    output logic                          hit,
    output logic [FRAME_INDEX_W-1:0]      frame_index,
    output logic                          evicted_valid,
    output logic [PAGE_BITS-1:0]          evicted_page,
    output logic [TOTAL_W-1:0]            hit_total,
    output logic [TOTAL_W-1:0]            fault_total
);

    lru_cmd_t    cmd;
    lru_status_t status;

    // sequencer: idle -> scan (one frame per cycle) -> update
    lru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready)
    );

    // frame table, recency ranks, totals and result registers
    lru_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .page_number   (page_number),
        .result_valid  (result_valid),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total),
        .fault_total   (fault_total)
    );

endmodule

`default_nettype wire

// ===== design/lru_ctrl.sv =====
`default_nettype none

module lru_ctrl
    import lru_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire lru_status_t status,
    output lru_cmd_t         cmd,
    output logic             busy,
    output logic             cfg_ready
);

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [ST_W-1:0] ST_SCAN   = 2'd1;
    localparam logic [ST_W-1:0] ST_UPDATE = 2'd2;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.update = (state_reg == ST_UPDATE);
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ===== design/lru_dp.sv =====
`default_nettype none

module lru_dp
    import lru_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lru_cmd_t                 cmd,
    output lru_status_t                   status,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic [PAGE_BITS-1:0]     page_number,
    output logic                          result_valid,
    output logic                          hit,
    output logic [FRAME_INDEX_W-1:0]      frame_index,
    output logic                          evicted_valid,
    output logic [PAGE_BITS-1:0]          evicted_page,
    output logic [TOTAL_W-1:0]            hit_total,
    output logic [TOTAL_W-1:0]            fault_total
);

    localparam logic [RANK_W-1:0]  RANK_OLDEST = RANK_W'(MAX_FRAMES - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX     = CNT_W'(MAX_FRAMES);
    localparam logic [TOTAL_W-1:0] TOTAL_SAT   = '1;

    logic [CFG_W-1:0]     frames_in_use_reg;

    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     last_idx_reg, last_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 empty_reg, empty_next;
    logic [IDX_W-1:0]     empty_idx_reg, empty_idx_next;
    logic [RANK_W-1:0]    oldest_rank_reg, oldest_rank_next;
    logic [IDX_W-1:0]     oldest_idx_reg, oldest_idx_next;
    logic [PAGE_BITS-1:0] oldest_page_reg, oldest_page_next;

    logic [PAGE_BITS-1:0] frame_page_reg [MAX_FRAMES];
    logic                 frame_valid_reg [MAX_FRAMES];
    logic [RANK_W-1:0]    rank_reg [MAX_FRAMES];
    logic [RANK_W-1:0]    rank_next [MAX_FRAMES];

    logic [TOTAL_W-1:0]   hit_total_reg, fault_total_reg;
    logic                 result_valid_reg;
    logic                 hit_reg;
    logic [FRAME_INDEX_W-1:0] frame_index_reg;
    logic                 evicted_valid_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;

    logic [CNT_W-1:0]     active_cnt;
    logic [IDX_W-1:0]     cur_idx;
    logic                 cur_valid;
    logic [PAGE_BITS-1:0] cur_page;
    logic [RANK_W-1:0]    cur_rank;
    logic [IDX_W-1:0]     sel_idx;
    logic [RANK_W-1:0]    limit;
    logic                 do_evict;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            frames_in_use_reg <= cfg_data;
        end
    end

    // zero acts as one, oversize clamps to the frame count
    always_comb
    begin
        priority if (frames_in_use_reg == '0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (32'(frames_in_use_reg) > MAX_FRAMES)
        begin
            active_cnt = CNT_MAX;
        end
        else
        begin
            active_cnt = CNT_W'(frames_in_use_reg);
        end
    end

    assign cur_idx   = scan_idx_reg[IDX_W-1:0];
    assign cur_valid = frame_valid_reg[cur_idx];
    assign cur_page  = frame_page_reg[cur_idx];
    assign cur_rank  = rank_reg[cur_idx];

    assign status.scan_last = (scan_idx_reg == last_idx_reg);

    // one frame per cycle: first match, first empty, oldest
    always_comb
    begin
        scan_idx_next    = scan_idx_reg;
        last_idx_next    = last_idx_reg;
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        empty_next       = empty_reg;
        empty_idx_next   = empty_idx_reg;
        oldest_rank_next = oldest_rank_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_page_next = oldest_page_reg;
        if (cmd.load)
        begin
            scan_idx_next = '0;
            last_idx_next = active_cnt - CNT_W'(1);
            found_next    = 1'b0;
            empty_next    = 1'b0;
        end
        else if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
            if (!found_reg && cur_valid && (cur_page == page_reg))
            begin
                found_next     = 1'b1;
                match_idx_next = cur_idx;
            end
            if (!empty_reg && !cur_valid)
            begin
                empty_next     = 1'b1;
                empty_idx_next = cur_idx;
            end
            if ((scan_idx_reg == '0) || (cur_rank > oldest_rank_reg))
            begin
                oldest_rank_next = cur_rank;
                oldest_idx_next  = cur_idx;
                oldest_page_next = cur_page;
            end
        end
    end

    always_comb
    begin
        priority if (found_reg)
        begin
            sel_idx = match_idx_reg;
        end
        else if (empty_reg)
        begin
            sel_idx = empty_idx_reg;
        end
        else
        begin
            sel_idx = oldest_idx_reg;
        end
    end

    assign do_evict = !found_reg && !empty_reg;
    // touch ages frames younger than the hit frame; a fill ages all but the cap
    assign limit    = found_reg ? rank_reg[sel_idx] : RANK_OLDEST;

    always_comb
    begin
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            rank_next[k] = rank_reg[k];
            if (IDX_W'(k) == sel_idx)
            begin
                rank_next[k] = '0;
            end
            else if (frame_valid_reg[k] && (rank_reg[k] < limit))
            begin
                rank_next[k] = rank_reg[k] + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg         <= cmd.load ? page_number : page_reg;
        match_idx_reg    <= match_idx_next;
        empty_idx_reg    <= empty_idx_next;
        oldest_rank_reg  <= oldest_rank_next;
        oldest_idx_reg   <= oldest_idx_next;
        oldest_page_reg  <= oldest_page_next;
        last_idx_reg     <= last_idx_next;
        hit_reg          <= cmd.update ? found_reg : hit_reg;
        frame_index_reg  <= cmd.update ? FRAME_INDEX_W'(sel_idx) : frame_index_reg;
        evicted_valid_reg <= cmd.update ? do_evict : evicted_valid_reg;
        if (cmd.update)
        begin
            evicted_page_reg <= do_evict ? oldest_page_reg : '0;
            if (!found_reg)
            begin
                frame_page_reg[sel_idx] <= page_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg     <= '0;
            found_reg        <= 1'b0;
            empty_reg        <= 1'b0;
            hit_total_reg    <= '0;
            fault_total_reg  <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                frame_valid_reg[k] <= 1'b0;
                rank_reg[k]        <= '0;
            end
        end
        else
        begin
            scan_idx_reg     <= scan_idx_next;
            found_reg        <= found_next;
            empty_reg        <= empty_next;
            result_valid_reg <= cmd.update;
            if (cmd.update)
            begin
                for (int k = 0; k < MAX_FRAMES; k++)
                begin
                    rank_reg[k] <= rank_next[k];
                end
                if (found_reg)
                begin
                    if (hit_total_reg != TOTAL_SAT)
                    begin
                        hit_total_reg <= hit_total_reg + TOTAL_W'(1);
                    end
                end
                else
                begin
                    frame_valid_reg[sel_idx] <= 1'b1;
                    if (fault_total_reg != TOTAL_SAT)
                    begin
                        fault_total_reg <= fault_total_reg + TOTAL_W'(1);
                    end
                end
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_total     = hit_total_reg;
    assign fault_total   = fault_total_reg;

endmodule

`default_nettype wire

// ===== design/lru_chk.sv =====
`default_nettype none

module lru_chk
    import lru_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 result_valid,
    input  wire logic                 hit,
    input  wire logic                 evicted_valid,
    input  wire logic [PAGE_BITS-1:0] evicted_page,
    input  wire logic [TOTAL_W-1:0]   hit_total
);

    // a taken reference always raises busy in the following cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted reference did not raise busy");

    // end of work always delivers a result beat
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy fell without a result beat");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && hit) |-> !evicted_valid)
        else $error("hit reported an eviction");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !evicted_valid) |-> (evicted_page == '0))
        else $error("evicted page nonzero without eviction");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && hit) |-> (hit_total != '0))
        else $error("hit beat with zero hit total");

endmodule

bind lru_page_replacement lru_chk u_lru_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_valid  (result_valid),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .hit_total     (hit_total)
);

`default_nettype wire
